@@ rtl/ias_pkg.sv @@
`timescale 1ns / 1ps

package ias_pkg;

  localparam int unsigned MagW   = 15;
  localparam int unsigned DriveW = 16;
  localparam int unsigned RelayW = 2;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 2;

  // handler phases
  localparam logic [PhaseW-1:0] H_UP         = 3'd0;
  localparam logic [PhaseW-1:0] H_GOING_UP   = 3'd1;
  localparam logic [PhaseW-1:0] H_GOING_DOWN = 3'd2;
  localparam logic [PhaseW-1:0] H_DOWN       = 3'd3;
  localparam logic [PhaseW-1:0] H_GRAB_IN    = 3'd4;
  localparam logic [PhaseW-1:0] H_EJECT      = 3'd5;

  // arm phases
  localparam logic [PhaseW-1:0] A_FOLD_IN  = 3'd0;
  localparam logic [PhaseW-1:0] A_FOLD_OUT = 3'd1;
  localparam logic [PhaseW-1:0] A_IN       = 3'd2;
  localparam logic [PhaseW-1:0] A_OUT      = 3'd3;
  localparam logic [PhaseW-1:0] A_DOWN     = 3'd4;

  localparam logic [RelayW-1:0] RELAY_OFF = 2'd0;
  localparam logic [RelayW-1:0] RELAY_FWD = 2'd1;
  localparam logic [RelayW-1:0] RELAY_REV = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_SPINNER_SPEED  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ARM_HOLD_IN    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ARM_HOLD_OUT   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_ARM_FOLD_SPEED = 2'd3;

  localparam logic [MagW-1:0] SPINNER_SPEED_RST  = 15'd24576;
  localparam logic [MagW-1:0] ARM_HOLD_IN_RST    = 15'd262;
  localparam logic [MagW-1:0] ARM_HOLD_OUT_RST   = 15'd328;
  localparam logic [MagW-1:0] ARM_FOLD_SPEED_RST = 15'd11469;

  typedef struct packed {
    logic home_button;
    logic grab_button;
    logic shoot_button;
    logic up_button;
    logic spin_reverse_button;
    logic ball_present;
    logic handler_up_switch;
    logic handler_down_switch;
    logic arm_out_switch;
    logic arm_in_switch;
    logic arm_low_switch;
  } in_item_t;

  typedef struct packed {
    logic [RelayW-1:0]        belt_relay;
    logic [RelayW-1:0]        tilt_relay;
    logic signed [DriveW-1:0] spinner_drive;
    logic signed [DriveW-1:0] arm_drive;
    logic [PhaseW-1:0]        handler_mode;
    logic [PhaseW-1:0]        arm_mode;
  } out_item_t;

  typedef struct packed {
    logic [MagW-1:0] spinner_speed;
    logic [MagW-1:0] arm_hold_in;
    logic [MagW-1:0] arm_hold_out;
    logic [MagW-1:0] arm_fold_speed;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] handler;
    logic [PhaseW-1:0] arm;
  } phase_t;

  function automatic logic signed [DriveW-1:0] pos_q15(input logic [MagW-1:0] mag);
    pos_q15 = signed'({1'b0, mag});
  endfunction

  function automatic logic signed [DriveW-1:0] neg_q15(input logic [MagW-1:0] mag);
    neg_q15 = -signed'({1'b0, mag});
  endfunction

endpackage

@@ rtl/intake_arm_sequencer_core.sv @@
`timescale 1ns / 1ps

// intake arm sequencer: one control tick in, one drive command out
// in channel: in_valid_i / in_ready_o carry one tick of buttons and switches
// out channel: out_valid_o / out_ready_i carry relay codes, drive values, modes
// config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the clock edge;
//   the user must write only while no tick is in flight, the block does not enforce it
// an accepted tick sits in the input register; the handler and arm machines
//   and the decode run in one pass into the result register at an edge where
//   the result register is empty or being taken
// throughput is one tick per cycle while the receiver takes the results
// the block takes a new tick while a result waits, as long as the input
//   register can drain or is empty
// when the receiver stalls, the result holds and at most one more tick is
//   kept in the input register; then in_ready_o drops
// reset: handler going up, arm folding in, registers at their defaults,
//   both stages empty
module intake_arm_sequencer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ias_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ias_pkg::out_item_t           out_item_o,
  input  logic                         cfg_we_i,
  input  logic [ias_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ias_pkg::MagW-1:0]     cfg_wdata_i
);
  import ias_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  phase_t    phase_q;
  phase_t    phase_d;
  cfg_t      cfg_q;
  out_item_t result;
  logic      advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  ias_step u_step (
    .item_i   (in_q),
    .phase_i  (phase_q),
    .cfg_i    (cfg_q),
    .phase_o  (phase_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      phase_q.handler <= H_GOING_UP;
      phase_q.arm     <= A_FOLD_IN;
      cfg_q.spinner_speed  <= SPINNER_SPEED_RST;
      cfg_q.arm_hold_in    <= ARM_HOLD_IN_RST;
      cfg_q.arm_hold_out   <= ARM_HOLD_OUT_RST;
      cfg_q.arm_fold_speed <= ARM_FOLD_SPEED_RST;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SPINNER_SPEED:  cfg_q.spinner_speed  <= cfg_wdata_i;
          REG_ARM_HOLD_IN:    cfg_q.arm_hold_in    <= cfg_wdata_i;
          REG_ARM_HOLD_OUT:   cfg_q.arm_hold_out   <= cfg_wdata_i;
          REG_ARM_FOLD_SPEED: cfg_q.arm_fold_speed <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

endmodule

@@ rtl/ias_step.sv @@
`timescale 1ns / 1ps

module ias_step (
  input  ias_pkg::in_item_t  item_i,
  input  ias_pkg::phase_t    phase_i,
  input  ias_pkg::cfg_t      cfg_i,
  output ias_pkg::phase_t    phase_o,
  output ias_pkg::out_item_t result_o
);
  import ias_pkg::*;

  logic [PhaseW-1:0] h_mid;
  logic [PhaseW-1:0] a_mid;
  logic [PhaseW-1:0] a_new;

  // handler machine, may also move the arm
  always_comb begin
    h_mid = phase_i.handler;
    a_mid = phase_i.arm;
    if (item_i.home_button) begin
      h_mid = H_GOING_UP;
      a_mid = A_FOLD_IN;
    end else begin
      case (phase_i.handler)
        H_UP: begin
          if (item_i.grab_button) begin
            h_mid = H_GOING_DOWN;
            a_mid = A_FOLD_OUT;
          end else if (item_i.shoot_button) begin
            h_mid = H_GOING_DOWN;
            a_mid = A_IN;
          end
        end
        H_DOWN: begin
          if (item_i.shoot_button) begin
            h_mid = H_EJECT;
            a_mid = A_FOLD_IN;
          end else if (item_i.grab_button) begin
            h_mid = H_GRAB_IN;
            a_mid = A_FOLD_OUT;
          end
        end
        H_GRAB_IN: begin
          if (item_i.up_button || item_i.ball_present) begin
            h_mid = H_GOING_UP;
            a_mid = A_FOLD_IN;
          end
        end
        H_EJECT: begin
          if (item_i.grab_button) begin
            h_mid = H_GOING_UP;
            a_mid = A_FOLD_IN;
          end
        end
        H_GOING_DOWN: begin
          if (item_i.up_button) begin
            h_mid = H_GOING_UP;
            a_mid = A_FOLD_IN;
          end else if (item_i.handler_down_switch) begin
            h_mid = H_DOWN;
          end
        end
        H_GOING_UP: begin
          // up switch wins over grab
          if (item_i.handler_up_switch) begin
            h_mid = H_UP;
            a_mid = A_FOLD_IN;
          end else if (item_i.grab_button) begin
            h_mid = H_GOING_DOWN;
            a_mid = A_FOLD_OUT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // arm machine from the arm state left by the handler
  always_comb begin
    a_new = a_mid;
    case (a_mid)
      A_FOLD_OUT: begin
        if (item_i.arm_low_switch) begin
          a_new = A_DOWN;
        end else if (item_i.arm_out_switch) begin
          a_new = A_OUT;
        end
      end
      A_FOLD_IN: begin
        if (item_i.arm_in_switch) begin
          a_new = A_IN;
        end
      end
      default: begin
      end
    endcase
  end

  // output decode
  always_comb begin
    result_o.belt_relay    = RELAY_OFF;
    result_o.tilt_relay    = RELAY_OFF;
    result_o.spinner_drive = '0;
    case (h_mid)
      H_GRAB_IN: begin
        result_o.belt_relay    = RELAY_REV;
        result_o.spinner_drive = item_i.spin_reverse_button ? neg_q15(cfg_i.spinner_speed)
                                                            : pos_q15(cfg_i.spinner_speed);
      end
      H_EJECT: begin
        result_o.belt_relay    = RELAY_FWD;
        result_o.spinner_drive = neg_q15(cfg_i.spinner_speed);
      end
      H_GOING_DOWN: begin
        result_o.belt_relay = RELAY_REV;
        result_o.tilt_relay = RELAY_REV;
      end
      H_GOING_UP: begin
        result_o.tilt_relay = RELAY_FWD;
      end
      default: begin
      end
    endcase

    case (a_new)
      A_IN:       result_o.arm_drive = neg_q15(cfg_i.arm_hold_in);
      A_OUT:      result_o.arm_drive = pos_q15(cfg_i.arm_hold_out);
      A_FOLD_IN:  result_o.arm_drive = neg_q15(cfg_i.arm_fold_speed);
      A_FOLD_OUT: result_o.arm_drive = pos_q15(cfg_i.arm_fold_speed);
      A_DOWN:     result_o.arm_drive = pos_q15(cfg_i.arm_fold_speed);
      default:    result_o.arm_drive = pos_q15(cfg_i.arm_hold_out);
    endcase

    result_o.handler_mode = h_mid;
    result_o.arm_mode     = a_new;
  end

  assign phase_o.handler = h_mid;
  assign phase_o.arm     = a_new;

endmodule

@@ dv/intake_arm_sequencer_core_tb.sv @@
`timescale 1ns / 1ps

module intake_arm_sequencer_core_tb;
  import ias_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLDOFF_CYCLES = 80;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [MagW-1:0]    cfg_wdata_i = '0;

  intake_arm_sequencer_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and register copies
  logic [PhaseW-1:0] hnd_st = H_GOING_UP;
  logic [PhaseW-1:0] arm_st = A_FOLD_IN;
  logic [MagW-1:0]   spin_mag = SPINNER_SPEED_RST;
  logic [MagW-1:0]   hold_in_mag = ARM_HOLD_IN_RST;
  logic [MagW-1:0]   hold_out_mag = ARM_HOLD_OUT_RST;
  logic [MagW-1:0]   fold_mag = ARM_FOLD_SPEED_RST;

  in_item_t  tick_q[$];
  out_item_t drive_cmd_q[$];

  int unsigned mismatches = 0;
  int unsigned ticks_taken = 0;
  int unsigned cmds_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_trig = 0;
  int unsigned hold_seen = 0;
  logic [7:0] hnd_modes_seen = '0;
  logic [7:0] arm_modes_seen = '0;
  logic in_taken = 1'b0;

  function automatic out_item_t advance_sequencer(in_item_t t);
    out_item_t r;
    logic [PhaseW-1:0] h;
    logic [PhaseW-1:0] a;
    h = hnd_st;
    a = arm_st;
    if (t.home_button) begin
      h = H_GOING_UP;
      a = A_FOLD_IN;
    end else begin
      case (h)
        H_UP: begin
          if (t.grab_button) begin
            h = H_GOING_DOWN;
            a = A_FOLD_OUT;
          end else if (t.shoot_button) begin
            h = H_GOING_DOWN;
            a = A_IN;
          end
        end
        H_DOWN: begin
          if (t.shoot_button) begin
            h = H_EJECT;
            a = A_FOLD_IN;
          end else if (t.grab_button) begin
            h = H_GRAB_IN;
            a = A_FOLD_OUT;
          end
        end
        H_GRAB_IN: begin
          if (t.up_button || t.ball_present) begin
            h = H_GOING_UP;
            a = A_FOLD_IN;
          end
        end
        H_EJECT: begin
          if (t.grab_button) begin
            h = H_GOING_UP;
            a = A_FOLD_IN;
          end
        end
        H_GOING_DOWN: begin
          if (t.up_button) begin
            h = H_GOING_UP;
            a = A_FOLD_IN;
          end else if (t.handler_down_switch) begin
            h = H_DOWN;
          end
        end
        H_GOING_UP: begin
          if (t.grab_button) begin
            h = H_GOING_DOWN;
            a = A_FOLD_OUT;
          end
          // up switch wins over grab
          if (t.handler_up_switch) begin
            h = H_UP;
            a = A_FOLD_IN;
          end
        end
        default: ;
      endcase
    end
    if (a == A_FOLD_OUT) begin
      if (t.arm_out_switch) a = A_OUT;
      if (t.arm_low_switch) a = A_DOWN;
    end else if (a == A_FOLD_IN) begin
      if (t.arm_in_switch) a = A_IN;
    end

    r = '0;
    r.belt_relay = RELAY_OFF;
    r.tilt_relay = RELAY_OFF;
    case (h)
      H_GRAB_IN: begin
        r.belt_relay = RELAY_REV;
        r.spinner_drive = t.spin_reverse_button ? -{1'b0, spin_mag} : {1'b0, spin_mag};
      end
      H_EJECT: begin
        r.belt_relay = RELAY_FWD;
        r.spinner_drive = -{1'b0, spin_mag};
      end
      H_GOING_DOWN: begin
        r.belt_relay = RELAY_REV;
        r.tilt_relay = RELAY_REV;
      end
      H_GOING_UP: r.tilt_relay = RELAY_FWD;
      default: ;
    endcase
    case (a)
      A_IN:       r.arm_drive = -{1'b0, hold_in_mag};
      A_OUT:      r.arm_drive = {1'b0, hold_out_mag};
      A_FOLD_IN:  r.arm_drive = -{1'b0, fold_mag};
      A_FOLD_OUT: r.arm_drive = {1'b0, fold_mag};
      A_DOWN:     r.arm_drive = {1'b0, fold_mag};
      default:    r.arm_drive = {1'b0, hold_out_mag};
    endcase
    r.handler_mode = h;
    r.arm_mode = a;
    hnd_st = h;
    arm_st = a;
    return r;
  endfunction

  task automatic flag_mismatch(string field, int unsigned got, int unsigned want);
    mismatches++;
    $display("result %0d %s: got %0h want %0h", cmds_checked, field, got, want);
  endtask

  // monitor, predictor feed and watchdog
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (drive_cmd_q.size() == 0) begin
          flag_mismatch("unexpected item", 32'(out_item_o), 0);
        end else begin
          want = drive_cmd_q.pop_front();
          if (out_item_o.belt_relay !== want.belt_relay)
            flag_mismatch("belt_relay", out_item_o.belt_relay, want.belt_relay);
          if (out_item_o.tilt_relay !== want.tilt_relay)
            flag_mismatch("tilt_relay", out_item_o.tilt_relay, want.tilt_relay);
          if (out_item_o.spinner_drive !== want.spinner_drive)
            flag_mismatch("spinner_drive", out_item_o.spinner_drive, want.spinner_drive);
          if (out_item_o.arm_drive !== want.arm_drive)
            flag_mismatch("arm_drive", out_item_o.arm_drive, want.arm_drive);
          if (out_item_o.handler_mode !== want.handler_mode)
            flag_mismatch("handler_mode", out_item_o.handler_mode, want.handler_mode);
          if (out_item_o.arm_mode !== want.arm_mode)
            flag_mismatch("arm_mode", out_item_o.arm_mode, want.arm_mode);
          hnd_modes_seen[want.handler_mode] = 1'b1;
          arm_modes_seen[want.arm_mode] = 1'b1;
        end
        cmds_checked++;
      end
      if (in_valid_i && in_ready_o) begin
        drive_cmd_q.push_back(advance_sequencer(in_item_i));
        ticks_taken++;
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // sender: bursts of items with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (tick_q.size() > 0) begin
        in_item_i <= tick_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall styles that change over time, plus long hold-offs on request
  int unsigned hold_left = 0;
  int unsigned style_left = 0;
  int unsigned stall_style = 0;
  int unsigned pat_cnt = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_seen != hold_trig) begin
        hold_seen = hold_trig;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (style_left == 0) begin
          stall_style = $urandom_range(0, 3);
          style_left = $urandom_range(20, 120);
        end
        style_left--;
        pat_cnt++;
        case (stall_style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ((pat_cnt % 5) < 3);
        endcase
      end
    end
  end

  function automatic in_item_t make_tick();
    in_item_t t;
    if ($urandom_range(0, 9) == 0) begin
      t = in_item_t'(11'($urandom));
    end else begin
      t.home_button         = ($urandom_range(0, 31) == 0);
      t.grab_button         = ($urandom_range(0, 3) == 0);
      t.shoot_button        = ($urandom_range(0, 4) == 0);
      t.up_button           = ($urandom_range(0, 6) == 0);
      t.spin_reverse_button = 1'($urandom_range(0, 1));
      t.ball_present        = ($urandom_range(0, 6) == 0);
      t.handler_up_switch   = ($urandom_range(0, 3) == 0);
      t.handler_down_switch = ($urandom_range(0, 3) == 0);
      t.arm_out_switch      = ($urandom_range(0, 3) == 0);
      t.arm_in_switch       = ($urandom_range(0, 3) == 0);
      t.arm_low_switch      = ($urandom_range(0, 4) == 0);
    end
    return t;
  endfunction

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid_i || drive_cmd_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [MagW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    case (idx)
      REG_SPINNER_SPEED:  spin_mag = val;
      REG_ARM_HOLD_IN:    hold_in_mag = val;
      REG_ARM_HOLD_OUT:   hold_out_mag = val;
      REG_ARM_FOLD_SPEED: fold_mag = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic write_all_regs(logic [MagW-1:0] s, logic [MagW-1:0] hi,
                                logic [MagW-1:0] ho, logic [MagW-1:0] f);
    write_reg(REG_SPINNER_SPEED, s);
    write_reg(REG_ARM_HOLD_IN, hi);
    write_reg(REG_ARM_HOLD_OUT, ho);
    write_reg(REG_ARM_FOLD_SPEED, f);
  endtask

  task automatic queue_ticks(int unsigned n);
    repeat (n) tick_q.push_back(make_tick());
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed walk through every transition, default registers
    // field order: home grab shoot up spin_rev _ ball _ up_sw down_sw _ out in low
    tick_q.push_back(in_item_t'(11'b00000_0_00_000));
    tick_q.push_back(in_item_t'(11'b10000_0_00_010));
    tick_q.push_back(in_item_t'(11'b01000_0_10_000)); // grab and up switch together
    tick_q.push_back(in_item_t'(11'b00100_0_00_000));
    tick_q.push_back(in_item_t'(11'b00000_0_01_000));
    tick_q.push_back(in_item_t'(11'b01000_0_00_101)); // out and low switch together
    tick_q.push_back(in_item_t'(11'b00001_0_00_000));
    tick_q.push_back(in_item_t'(11'b00000_1_00_000));
    tick_q.push_back(in_item_t'(11'b01000_0_00_100));
    tick_q.push_back(in_item_t'(11'b00010_0_00_000));
    tick_q.push_back(in_item_t'(11'b00000_0_10_000));
    tick_q.push_back(in_item_t'(11'b01000_0_00_000));
    tick_q.push_back(in_item_t'(11'b00000_0_01_000));
    tick_q.push_back(in_item_t'(11'b00100_0_00_000));
    tick_q.push_back(in_item_t'(11'b00000_0_00_000));
    tick_q.push_back(in_item_t'(11'b01000_0_00_010));
    tick_q.push_back(in_item_t'(11'b00000_0_10_000));
    tick_q.push_back(in_item_t'(11'b01100_0_00_001));
    tick_q.push_back(in_item_t'(11'b00000_0_01_000));
    tick_q.push_back(in_item_t'(11'b01100_0_00_000));
    tick_q.push_back(in_item_t'(11'b00010_1_00_000));
    tick_q.push_back(in_item_t'(11'b01000_0_00_010));
    tick_q.push_back(in_item_t'(11'b00000_0_10_000));
    tick_q.push_back(in_item_t'(11'b11111_1_11_111));
    tick_q.push_back(in_item_t'(11'b00000_0_01_000));
    wait_drained();

    // full-scale magnitudes, with a long receiver hold-off mid-stream
    write_all_regs(15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
    queue_ticks(400);
    while (tick_q.size() > 300) @(negedge clk_i);
    hold_trig++;
    wait_drained();

    // zero magnitudes, sender pauses until every result is back
    write_all_regs(15'h0000, 15'h0000, 15'h0000, 15'h0000);
    queue_ticks(200);
    wait_drained();
    queue_ticks(200);
    wait_drained();

    write_all_regs(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom));
    queue_ticks(400);
    while (tick_q.size() > 150) @(negedge clk_i);
    hold_trig++;
    wait_drained();

    write_all_regs(15'h0001, 15'h4000, 15'h7ffe, 15'h2aaa);
    queue_ticks(400);
    wait_drained();
    repeat (6) @(posedge clk_i);

    $display("%0d ticks sent, %0d checked over %0d register writes, %0d receiver hold-offs",
             ticks_taken, cmds_checked, cfg_writes, hold_trig);
    $display("handler modes seen %b, arm modes seen %b",
             hnd_modes_seen[5:0], arm_modes_seen[4:0]);
    if (mismatches == 0 && drive_cmd_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, drive_cmd_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ias_pkg.sv
rtl/ias_step.sv
rtl/intake_arm_sequencer_core.sv
dv/intake_arm_sequencer_core_tb.sv
